### src/ght_pkg.sv
// ----------------------------------------------------------------------------
// generational handle table package
// shared widths, request and status codes, and the request/result structs
// ----------------------------------------------------------------------------
`default_nettype none

package ght_pkg;

	localparam int NUM_SLOTS = 256;
	localparam int IDX_W      = 8;
	localparam int CNT_W      = 9;
	localparam int GEN_W      = 32;

	localparam logic [1:0] REQ_ALLOC   = 2'd0;
	localparam logic [1:0] REQ_LOOKUP  = 2'd1;
	localparam logic [1:0] REQ_RELEASE = 2'd2;
	localparam logic [1:0] REQ_COLLECT = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_STALE = 2'd2;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [IDX_W-1:0] slot_index;
		logic [GEN_W-1:0] handle_gen;
	} req_t;

	typedef struct packed {
		logic [IDX_W-1:0] out_index;
		logic [GEN_W-1:0] out_gen;
		logic [1:0]       status;
		logic [CNT_W-1:0] freed_count;
		logic [CNT_W-1:0] live_slots;
	} rsp_t;

endpackage

`default_nettype wire

### src/generational_handle_table_top.sv
// ----------------------------------------------------------------------------
// generational handle table
// slot table handing out index plus generation handles, with deferred free
// ----------------------------------------------------------------------------
// channel   direction  handshake                      payload
// request   in         start && !busy                 req (ght_pkg::req_t)
// result    out        done, one cycle, no back-off   rsp (ght_pkg::rsp_t)
//
// allocate, look up and release: S_RD makes a registered read of the slot
// generation memory, then S_EXEC does compare/increment and write back and
// registers done; busy drops with done, so a new request waits for the last.
// collect: done is raised once every pending index has been walked; each
// queued index takes a queue read, a generation read and a bump/write.
// reset clears all control state and the occupied/live bits; generations clear
// through per-slot valid bits. the receiver cannot stall, busy holds off start.
// ----------------------------------------------------------------------------
`default_nettype none

module generational_handle_table_top (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	output logic              busy,
	input  ght_pkg::req_t     req,
	output logic              done,
	output ght_pkg::rsp_t     rsp
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_EXEC = 3'd2;
	localparam logic [2:0] S_QRD  = 3'd3;
	localparam logic [2:0] S_QGEN = 3'd4;
	localparam logic [2:0] S_QUPD = 3'd5;

	logic [2:0] state_q;
	ght_pkg::req_t req_q;

	logic [ght_pkg::GEN_W-1:0] gen_mem [ght_pkg::NUM_SLOTS];
	logic [ght_pkg::IDX_W-1:0] stack_mem [ght_pkg::NUM_SLOTS];
	logic [ght_pkg::IDX_W-1:0] queue_mem [ght_pkg::NUM_SLOTS];
	logic [ght_pkg::NUM_SLOTS-1:0] gen_vld_q, occ_q, live_q;

	logic [ght_pkg::CNT_W-1:0] free_top_q, pend_q, hw_q, live_tot_q, freed_q, walk_q;
	logic [ght_pkg::GEN_W-1:0] gen_rd_q;
	logic                      gen_v_q;
	logic [ght_pkg::IDX_W-1:0] stk_rd_q, q_rd_q, slot_q;

	// shared generation unit
	logic [ght_pkg::GEN_W-1:0] cur_gen, nxt_gen;
	logic                      gen_eq;
	always_comb begin
		cur_gen = gen_v_q ? gen_rd_q : '0;
		nxt_gen = cur_gen + ght_pkg::GEN_W'(1);
		if (nxt_gen == '0)
			nxt_gen = ght_pkg::GEN_W'(1);
		gen_eq = (cur_gen == req_q.handle_gen);
	end

	logic [ght_pkg::IDX_W-1:0] rd_addr;
	logic handle_ok, alloc_stack, alloc_hw;
	always_comb begin
		alloc_stack = (free_top_q != '0);
		alloc_hw    = !alloc_stack && (hw_q < ght_pkg::CNT_W'(ght_pkg::NUM_SLOTS));
		handle_ok = (req_q.handle_gen != '0)
			&& (ght_pkg::CNT_W'(req_q.slot_index) < hw_q)
			&& occ_q[req_q.slot_index] && live_q[req_q.slot_index] && gen_eq;
		if (state_q == S_QGEN)
			rd_addr = q_rd_q;
		else if (req_q.req_type == ght_pkg::REQ_ALLOC)
			rd_addr = alloc_stack ? stk_rd_q : hw_q[ght_pkg::IDX_W-1:0];
		else
			rd_addr = req_q.slot_index;
	end

	assign busy = (state_q != S_IDLE);

	// memories
	logic                      gen_we;
	logic [ght_pkg::IDX_W-1:0] gen_wa;
	logic [ght_pkg::IDX_W-1:0] stk_ra;
	always_comb begin
		stk_ra = free_top_q[ght_pkg::IDX_W-1:0] - ght_pkg::IDX_W'(1);
		gen_we = 1'b0;
		gen_wa = slot_q;
		if (state_q == S_EXEC && req_q.req_type == ght_pkg::REQ_ALLOC
			&& (alloc_stack || alloc_hw))
			gen_we = 1'b1;
		if (state_q == S_QUPD && occ_q[slot_q] && ght_pkg::CNT_W'(slot_q) < hw_q)
			gen_we = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (gen_we)
			gen_mem[gen_wa] <= nxt_gen;
		gen_rd_q <= gen_mem[rd_addr];
		stk_rd_q <= stack_mem[stk_ra];
		q_rd_q   <= queue_mem[walk_q[ght_pkg::IDX_W-1:0]];
		if (state_q == S_EXEC && req_q.req_type == ght_pkg::REQ_RELEASE && handle_ok
			&& pend_q < ght_pkg::CNT_W'(ght_pkg::NUM_SLOTS))
			queue_mem[pend_q[ght_pkg::IDX_W-1:0]] <= req_q.slot_index;
		if (gen_we && state_q == S_QUPD
			&& free_top_q < ght_pkg::CNT_W'(ght_pkg::NUM_SLOTS))
			stack_mem[free_top_q[ght_pkg::IDX_W-1:0]] <= slot_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			done       <= 1'b0;
			rsp        <= '0;
			slot_q     <= '0;
			gen_vld_q  <= '0;
			occ_q      <= '0;
			live_q     <= '0;
			free_top_q <= '0;
			pend_q     <= '0;
			hw_q       <= '0;
			live_tot_q <= '0;
			freed_q    <= '0;
			walk_q     <= '0;
			gen_v_q    <= 1'b0;
		end else begin
			done <= 1'b0;
			gen_v_q <= gen_vld_q[rd_addr];
			if (gen_we)
				gen_vld_q[gen_wa] <= 1'b1;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						freed_q <= '0;
						walk_q  <= '0;
						state_q <= (req.req_type == ght_pkg::REQ_COLLECT) ? S_QRD : S_RD;
					end
				end
				S_RD: begin
					slot_q  <= rd_addr;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					rsp.out_index   <= req_q.slot_index;
					rsp.out_gen     <= '0;
					rsp.status      <= ght_pkg::ST_OK;
					rsp.freed_count <= '0;
					rsp.live_slots  <= live_tot_q;
					done            <= 1'b1;
					state_q         <= S_IDLE;
					case (req_q.req_type)
						ght_pkg::REQ_ALLOC: begin
							if (alloc_stack || alloc_hw) begin
								if (alloc_stack)
									free_top_q <= free_top_q - ght_pkg::CNT_W'(1);
								else
									hw_q <= hw_q + ght_pkg::CNT_W'(1);
								occ_q[slot_q]  <= 1'b1;
								live_q[slot_q] <= 1'b1;
								live_tot_q     <= live_tot_q + ght_pkg::CNT_W'(1);
								rsp.live_slots <= live_tot_q + ght_pkg::CNT_W'(1);
								rsp.out_index  <= slot_q;
								rsp.out_gen    <= nxt_gen;
							end else
								rsp.status <= ght_pkg::ST_FULL;
						end
						ght_pkg::REQ_LOOKUP: begin
							if (!handle_ok)
								rsp.status <= ght_pkg::ST_STALE;
						end
						ght_pkg::REQ_RELEASE: begin
							if (!handle_ok)
								rsp.status <= ght_pkg::ST_STALE;
							else begin
								live_q[req_q.slot_index] <= 1'b0;
								if (live_tot_q != '0) begin
									live_tot_q     <= live_tot_q - ght_pkg::CNT_W'(1);
									rsp.live_slots <= live_tot_q - ght_pkg::CNT_W'(1);
								end
								if (pend_q < ght_pkg::CNT_W'(ght_pkg::NUM_SLOTS))
									pend_q <= pend_q + ght_pkg::CNT_W'(1);
							end
						end
						default: ;
					endcase
				end
				S_QRD: begin
					// queue read address is walk_q, data lands next cycle
					if (walk_q >= pend_q) begin
						rsp.out_index   <= req_q.slot_index;
						rsp.out_gen     <= '0;
						rsp.status      <= ght_pkg::ST_OK;
						rsp.freed_count <= freed_q;
						rsp.live_slots  <= live_tot_q;
						done            <= 1'b1;
						pend_q          <= '0;
						state_q         <= S_IDLE;
					end else
						state_q <= S_QGEN;
				end
				S_QGEN: begin
					slot_q  <= q_rd_q;
					state_q <= S_QUPD;
				end
				S_QUPD: begin
					if (gen_we) begin
						occ_q[slot_q]  <= 1'b0;
						live_q[slot_q] <= 1'b0;
						if (free_top_q < ght_pkg::CNT_W'(ght_pkg::NUM_SLOTS))
							free_top_q <= free_top_q + ght_pkg::CNT_W'(1);
						freed_q <= freed_q + ght_pkg::CNT_W'(1);
					end
					walk_q  <= walk_q + ght_pkg::CNT_W'(1);
					state_q <= S_QRD;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy)
			req_q <= req;
	end

	// transfer of a result always ends a busy period
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while busy");
	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		live_tot_q <= hw_q) else $error("live count above high water");
	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_top_q <= hw_q) else $error("free stack above high water");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted request not busy");

endmodule

`default_nettype wire
